>>> design/afr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

  // Frame store geometry
  localparam int FRAME_BYTES = 4096;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int CNT_W       = ADDR_W + 1;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int PKT_LEN_W = 12;
  localparam int CHAN_W    = 2;
  localparam int NUM_CHAN  = 4;
  localparam int ADR_CFG_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CMP_W     = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 2;

  // Frame framing constants
  localparam int HEADER_BYTES   = 1;
  localparam int CSUM_BYTES     = 1;
  localparam int LEN_LAST_BYTE  = 3;
  localparam int LEN_HI_BYTE    = 2;
  localparam int MIN_BYTES      = 4;
  localparam int FRAME_OVERHEAD = 4;
  localparam logic [BYTE_W-1:0] BROADCAST_ADDR = 8'd255;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_GAP  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    VERDICT_UNICAST   = 3'd0,
    VERDICT_BROADCAST = 3'd1,
    VERDICT_BAD_SUM   = 3'd2,
    VERDICT_NOT_ADDR  = 3'd3,
    VERDICT_DISCARD   = 3'd4
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHAN0 = 3'd0,
    CFG_CHAN1 = 3'd1,
    CFG_CHAN2 = 3'd2,
    CFG_CHAN3 = 3'd3,
    CFG_HS    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [NUM_CHAN-1:0][ADR_CFG_W-1:0] chan_addr;
    logic                               high_speed;
  } cfg_t;

  // One classified item handed from front to back
  typedef struct packed {
    logic                 wr;
    logic [ADDR_W-1:0]    wr_addr;
    logic [BYTE_W-1:0]    wr_data;
    logic                 fin;
    logic                 discard;
    logic                 sum_ok;
    logic [BYTE_W-1:0]    dest;
    logic [PKT_LEN_W-1:0] pkt_len;
  } cmd_t;

endpackage

`default_nettype wire

>>> design/afr_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface afr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [afr_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, kind, rx_byte, input ready);
  modport sink (input valid, kind, rx_byte, output ready);
endinterface

interface afr_out_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     verdict;
  logic [afr_pkg::CHAN_W-1:0]     channel;
  logic [afr_pkg::PKT_LEN_W-1:0]  packet_length;

  modport source (output valid, verdict, channel, packet_length, input ready);
  modport sink (input valid, verdict, channel, packet_length, output ready);
endinterface

`default_nettype wire

>>> design/afr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module afr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/afr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module afr_front (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  afr_in_if.sink      in_if,
  input  wire logic   high_speed_i,
  input  wire logic   q_ready_i,
  output logic        push_o,
  output afr_pkg::cmd_t cmd_o
);

  logic [afr_pkg::CNT_W-1:0]  cnt_q, cnt_d, cnt_nx;
  logic [afr_pkg::BYTE_W-1:0] sum_q, sum_d, sum_nx;
  logic [afr_pkg::LEN_W-1:0]  len_q, len_d, len_nx;
  logic [afr_pkg::BYTE_W-1:0] dest_q, dest_d, dest_nx;
  logic [afr_pkg::CNT_W-1:0]  plen_full;
  logic                       accept;
  afr_pkg::cmd_t              cmd;

  assign in_if.ready = q_ready_i;
  assign accept      = in_if.valid && q_ready_i;

  // Frame state after the byte is taken in
  always_comb begin
    cnt_nx  = cnt_q + afr_pkg::CNT_W'(1);
    sum_nx  = sum_q + in_if.rx_byte;
    dest_nx = (cnt_q == '0) ? in_if.rx_byte : dest_q;
    len_nx  = len_q;
    if (cnt_q == afr_pkg::CNT_W'(afr_pkg::LEN_HI_BYTE)) begin
      len_nx = {in_if.rx_byte, len_q[afr_pkg::BYTE_W-1:0]};
    end else if (cnt_q == afr_pkg::CNT_W'(afr_pkg::LEN_LAST_BYTE)) begin
      len_nx = {len_q[afr_pkg::LEN_W-1:afr_pkg::BYTE_W], in_if.rx_byte};
    end
    plen_full = cnt_nx - afr_pkg::CNT_W'(afr_pkg::HEADER_BYTES + afr_pkg::CSUM_BYTES);
  end

  // Classify the item and build the command for the back part
  always_comb begin
    cmd         = '0;
    cmd.wr_addr = cnt_q[afr_pkg::ADDR_W-1:0];
    cmd.wr_data = in_if.rx_byte;
    cmd.dest    = dest_nx;
    cmd.sum_ok  = (sum_nx == '0);
    cmd.pkt_len = afr_pkg::PKT_LEN_W'(plen_full);
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    len_d  = len_q;
    dest_d = dest_q;
    if (in_if.kind == afr_pkg::KIND_GAP) begin
      if (high_speed_i && (cnt_q != '0)) begin
        cmd.fin     = 1'b1;
        cmd.discard = 1'b1;
      end
    end else if (cnt_q < afr_pkg::CNT_W'(afr_pkg::FRAME_BYTES)) begin
      cmd.wr = 1'b1;
      cnt_d  = cnt_nx;
      sum_d  = sum_nx;
      len_d  = len_nx;
      dest_d = dest_nx;
      if (cnt_nx == afr_pkg::CNT_W'(afr_pkg::MIN_BYTES) &&
          (afr_pkg::CMP_W'(len_nx) + afr_pkg::CMP_W'(afr_pkg::FRAME_OVERHEAD + 1) >
           afr_pkg::CMP_W'(afr_pkg::FRAME_BYTES))) begin
        cmd.fin     = 1'b1;
        cmd.discard = 1'b1;
      end else if (cnt_nx >= afr_pkg::CNT_W'(afr_pkg::MIN_BYTES) &&
                   (afr_pkg::CMP_W'(cnt_nx) >
                    afr_pkg::CMP_W'(len_nx) + afr_pkg::CMP_W'(afr_pkg::FRAME_OVERHEAD))) begin
        cmd.fin = 1'b1;
      end
    end
    if (cmd.discard) begin
      cmd.pkt_len = '0;
    end
    // Clear the frame state once a verdict is issued
    if (cmd.fin) begin
      cnt_d  = '0;
      sum_d  = '0;
      len_d  = '0;
      dest_d = '0;
    end
  end

  assign push_o = accept && (cmd.wr || cmd.fin);
  assign cmd_o  = cmd;

  // Advance frame state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      len_q  <= '0;
      dest_q <= '0;
    end else if (accept) begin
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      len_q  <= len_d;
      dest_q <= dest_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= afr_pkg::CNT_W'(afr_pkg::FRAME_BYTES))
    else $error("frame byte count beyond store size");

  a_gap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_if.kind == afr_pkg::KIND_GAP && high_speed_i) |=> (cnt_q == '0))
    else $error("idle gap in high speed mode left a partial frame");

  a_fin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd.fin) |=> (cnt_q == '0 && sum_q == '0))
    else $error("frame state not cleared after verdict");
`endif

endmodule

`default_nettype wire

>>> design/afr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module afr_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire afr_pkg::cmd_t cmd_i,
  output logic               ready_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output afr_pkg::cmd_t      cmd_o
);

  afr_pkg::cmd_t               slot_q [afr_pkg::QUEUE_DEPTH];
  logic [afr_pkg::QPTR_W-1:0]  wptr_q, rptr_q;
  logic [afr_pkg::QCNT_W-1:0]  count_q;
  logic                        do_push, do_pop;

  assign ready_o = (count_q != afr_pkg::QCNT_W'(afr_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = slot_q[rptr_q];

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + afr_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + afr_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + afr_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - afr_pkg::QCNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    afr_pkg::QPTR_W'(wptr_q - rptr_q) == count_q[afr_pkg::QPTR_W-1:0])
    else $error("queue pointers disagree with fill level");
`endif

endmodule

`default_nettype wire

>>> design/afr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module afr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire afr_pkg::cfg_t cfg_i,
  input  wire logic          valid_i,
  input  wire afr_pkg::cmd_t cmd_i,
  output logic               pop_o,
  afr_out_if.source          out_if
);

  logic                            out_valid_q;
  afr_pkg::verdict_e               verdict_q, verdict_d;
  logic [afr_pkg::CHAN_W-1:0]      channel_q, channel_d;
  logic [afr_pkg::PKT_LEN_W-1:0]   plen_q, plen_d;
  logic                            found;
  logic                            slot_free;

  assign slot_free = !out_valid_q || out_if.ready;
  assign pop_o     = valid_i && (!cmd_i.fin || slot_free);

  // Frame store: written as bytes arrive; its read port is unused here
  afr_ram #(
    .WIDTH (afr_pkg::BYTE_W),
    .DEPTH (afr_pkg::FRAME_BYTES)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (pop_o && cmd_i.wr),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (cmd_i.wr_data),
    .re_i    (1'b0),
    .raddr_i ('0),
    .rdata_o ()
  );

  // Form the verdict: discard first, then checksum, then channels (lowest index wins), then broadcast
  always_comb begin
    found     = 1'b0;
    channel_d = '0;
    for (int i = afr_pkg::NUM_CHAN - 1; i >= 0; i--) begin
      if (cmd_i.dest == afr_pkg::BYTE_W'(cfg_i.chan_addr[i])) begin
        found     = 1'b1;
        channel_d = afr_pkg::CHAN_W'(i);
      end
    end
    plen_d = cmd_i.pkt_len;
    if (cmd_i.discard) begin
      verdict_d = afr_pkg::VERDICT_DISCARD;
      channel_d = '0;
    end else if (!cmd_i.sum_ok) begin
      verdict_d = afr_pkg::VERDICT_BAD_SUM;
      channel_d = '0;
    end else if (found) begin
      verdict_d = afr_pkg::VERDICT_UNICAST;
    end else if (cmd_i.dest == afr_pkg::BROADCAST_ADDR) begin
      verdict_d = afr_pkg::VERDICT_BROADCAST;
      channel_d = '0;
    end else begin
      verdict_d = afr_pkg::VERDICT_NOT_ADDR;
      channel_d = '0;
    end
  end

  // Output register: load a verdict, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.fin) begin
      verdict_q <= verdict_d;
      channel_q <= channel_d;
      plen_q    <= plen_d;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.verdict       = verdict_q;
  assign out_if.channel       = channel_q;
  assign out_if.packet_length = plen_q;

`ifndef SYNTHESIS
  a_discard_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && verdict_q == afr_pkg::VERDICT_DISCARD) |->
      (plen_q == '0 && channel_q == '0))
    else $error("discard verdict carries length or channel");

  a_channel_unicast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && channel_q != '0) |-> (verdict_q == afr_pkg::VERDICT_UNICAST))
    else $error("channel set on a non-unicast verdict");
`endif

endmodule

`default_nettype wire

>>> design/addressed_frame_receiver_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Address-filtered serial frame receiver. Each input item is either a received
// byte or an idle gap on the line. Bytes go into a 4096-byte frame store and a
// running 8-bit sum; byte 0 is the destination and bytes 2..3 the declared
// length (high byte first). A frame is declared length + 5 bytes; on its last
// byte one result is issued: unicast ok with the matched channel, broadcast ok,
// bad sum, or not addressed, with packet length = frame bytes - 2. A declared
// length that does not fit the store, or an idle gap in high speed mode with a
// partial frame buffered, gives a discard result at once. The block takes one
// item per clock cycle while the queue has room; the front end classifies each
// item in the cycle it is accepted, a four-entry queue carries it to the back
// end, which writes the frame store and loads the output register when the item
// that ends its frame leaves the queue. Front and back stall independently, and
// input is held off only when the queue is full. The user must write the
// configuration registers (channel addresses, high speed mode) through the cfg
// port only while the block is idle; the block itself does not enforce this.
module addressed_frame_receiver_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  afr_in_if.sink                               in_if,
  afr_out_if.source                            out_if,
  input  wire logic                            cfg_we_i,
  input  wire logic [afr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [afr_pkg::ADR_CFG_W-1:0]   cfg_data_i
);

  afr_pkg::cfg_t cfg_q;
  logic          push, q_ready, q_valid, pop;
  afr_pkg::cmd_t push_cmd, pop_cmd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chan_addr[0] <= afr_pkg::ADR_CFG_W'(1);
      cfg_q.chan_addr[1] <= afr_pkg::ADR_CFG_W'(2);
      cfg_q.chan_addr[2] <= afr_pkg::ADR_CFG_W'(3);
      cfg_q.chan_addr[3] <= afr_pkg::ADR_CFG_W'(4);
      cfg_q.high_speed   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        afr_pkg::CFG_CHAN0: cfg_q.chan_addr[0] <= cfg_data_i;
        afr_pkg::CFG_CHAN1: cfg_q.chan_addr[1] <= cfg_data_i;
        afr_pkg::CFG_CHAN2: cfg_q.chan_addr[2] <= cfg_data_i;
        afr_pkg::CFG_CHAN3: cfg_q.chan_addr[3] <= cfg_data_i;
        afr_pkg::CFG_HS:    cfg_q.high_speed   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  afr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .high_speed_i (cfg_q.high_speed),
    .q_ready_i    (q_ready),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  afr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  afr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (q_valid),
    .cmd_i   (pop_cmd),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire
